@@ rtl/rdrt_pkg.sv @@
package rdrt_pkg;

    // Default store geometry
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    // Fixed field widths
    localparam int PIXEL_W   = 32;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int TOP_W     = 9;
    localparam int BOTTOM_W  = 10;

    localparam logic [CFG_W-1:0] RESET_SIZE = 10'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Position flags of one pixel, worked out when it is accepted
    typedef struct packed {
        logic sof;
        logic row_end;
        logic frame_last;
        logic have_prev;
    } pos_t;

    // One result word
    typedef struct packed {
        logic [TOP_W-1:0]    run_top;
        logic [BOTTOM_W-1:0] run_bottom;
        logic                rect_valid;
        logic                whole_frame;
        logic                frame_end;
        logic                any_change;
    } span_t;

endpackage

@@ rtl/rdrt_pixel_if.sv @@
interface rdrt_pixel_if
    import rdrt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    logic               start_of_frame;

    modport source (output valid, output pixel, output start_of_frame, input ready);
    modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

@@ rtl/rdrt_span_if.sv @@
interface rdrt_span_if
    import rdrt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [TOP_W-1:0]    run_top;
    logic [BOTTOM_W-1:0] run_bottom;
    logic                rect_valid;
    logic                whole_frame;
    logic                frame_end;
    logic                any_change;

    modport source (output valid, output run_top, output run_bottom, output rect_valid,
                    output whole_frame, output frame_end, output any_change, input ready);
    modport sink   (input valid, input run_top, input run_bottom, input rect_valid,
                    input whole_frame, input frame_end, input any_change, output ready);
endinterface

@@ rtl/rdrt_ram.sv @@
module rdrt_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    // Read-first: a read and a write to the same entry in one cycle return the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ rtl/rdrt_addr.sv @@
module rdrt_addr
    import rdrt_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 accept,
    input  logic                 sof,
    output logic [ADDR_W-1:0]    addr,
    output logic [ROW_W-1:0]     row,
    output pos_t                 pos
);
    localparam int WC_W = ((CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1)) + 1;
    localparam int HC_W = ((CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W : $clog2(MAX_HEIGHT + 1)) + 1;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             have_prev_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    logic [COL_W-1:0] col;
    logic [WC_W-1:0]  width_eff;
    logic [HC_W-1:0]  height_eff;

    // Clamp the size registers to [1, MAX]
    always_comb
    begin
        if (width_reg == '0)
            width_eff = WC_W'(1);
        else if (WC_W'(width_reg) > WC_W'(MAX_WIDTH))
            width_eff = WC_W'(MAX_WIDTH);
        else
            width_eff = WC_W'(width_reg);

        if (height_reg == '0)
            height_eff = HC_W'(1);
        else if (HC_W'(height_reg) > HC_W'(MAX_HEIGHT))
            height_eff = HC_W'(MAX_HEIGHT);
        else
            height_eff = HC_W'(height_reg);
    end

    assign col = sof ? '0 : col_reg;
    assign row = sof ? '0 : row_reg;

    assign pos.sof        = sof;
    assign pos.row_end    = (WC_W'(col) + WC_W'(1)) >= width_eff;
    assign pos.frame_last = (HC_W'(row) + HC_W'(1)) >= height_eff;
    assign pos.have_prev  = have_prev_reg;

    assign addr = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= RESET_SIZE;
            height_reg    <= RESET_SIZE;
            have_prev_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else if (cfg_we)
        begin
            // A size change voids the stored frame
            have_prev_reg <= 1'b0;
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
        else if (accept)
        begin
            if (!pos.row_end)
            begin
                col_reg <= col + COL_W'(1);
                row_reg <= row;
            end
            else
            begin
                col_reg <= '0;
                row_reg <= pos.frame_last ? '0 : row + ROW_W'(1);
                if (pos.frame_last)
                begin
                    have_prev_reg <= 1'b1;
                end
            end
        end
    end
endmodule

@@ rtl/rdrt_run.sv @@
module rdrt_run
    import rdrt_pkg::*;
#(
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  pos_t               pos_in,
    input  logic [ROW_W-1:0]   row_in,
    input  logic [PIXEL_W-1:0] pixel_in,
    input  logic [PIXEL_W-1:0] rdata,
    output logic               take,
    output logic               out_valid,
    input  logic               out_ready,
    output span_t              span
);
    logic               s1_valid_reg;
    pos_t               s1_pos_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;

    logic               row_diff_reg;
    logic               run_open_reg;
    logic [ROW_W-1:0]   run_begin_reg;
    logic               frame_changed_reg;

    logic               out_valid_reg;
    span_t              span_reg;

    logic               row_diff_next;
    logic               run_open_next;
    logic [ROW_W-1:0]   run_begin_next;
    logic               frame_changed_next;
    logic               emit;
    span_t              res;
    logic               advance;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign take      = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign span      = span_reg;

    always_comb
    begin
        logic             differs;
        logic             changed;
        logic             closed;
        logic [ROW_W:0]   row_inc;

        differs            = rdata != s1_pixel_reg;
        changed            = 1'b0;
        closed             = 1'b0;
        row_inc            = {1'b0, s1_row_reg} + (ROW_W + 1)'(1);
        row_diff_next      = row_diff_reg;
        run_open_next      = run_open_reg;
        run_begin_next     = run_begin_reg;
        frame_changed_next = frame_changed_reg;
        emit               = 1'b0;
        res                = '0;

        if (s1_pos_reg.sof)
        begin
            row_diff_next      = 1'b0;
            run_open_next      = 1'b0;
            run_begin_next     = '0;
            frame_changed_next = 1'b0;
        end

        if (!s1_pos_reg.row_end)
        begin
            row_diff_next = row_diff_next | differs;
        end
        else
        begin
            changed       = row_diff_next | differs;
            row_diff_next = 1'b0;
            if (!s1_pos_reg.have_prev)
            begin
                run_open_next = 1'b0;
                if (s1_pos_reg.frame_last)
                begin
                    emit               = 1'b1;
                    res.run_bottom     = BOTTOM_W'(row_inc);
                    res.rect_valid     = 1'b1;
                    res.whole_frame    = 1'b1;
                    res.frame_end      = 1'b1;
                    res.any_change     = 1'b1;
                    frame_changed_next = 1'b0;
                end
            end
            else
            begin
                if (changed && !run_open_next)
                begin
                    run_open_next  = 1'b1;
                    run_begin_next = s1_row_reg;
                end
                else if (!changed && run_open_next)
                begin
                    run_open_next      = 1'b0;
                    frame_changed_next = 1'b1;
                    closed             = 1'b1;
                    emit               = 1'b1;
                    res.run_top        = TOP_W'(run_begin_next);
                    res.run_bottom     = BOTTOM_W'(s1_row_reg);
                    res.rect_valid     = 1'b1;
                    res.frame_end      = s1_pos_reg.frame_last;
                    res.any_change     = s1_pos_reg.frame_last;
                end

                if (s1_pos_reg.frame_last)
                begin
                    if (run_open_next)
                    begin
                        run_open_next  = 1'b0;
                        emit           = 1'b1;
                        res.run_top    = TOP_W'(run_begin_next);
                        res.run_bottom = BOTTOM_W'(row_inc);
                        res.rect_valid = 1'b1;
                        res.frame_end  = 1'b1;
                        res.any_change = 1'b1;
                    end
                    else if (!closed)
                    begin
                        emit           = 1'b1;
                        res.frame_end  = 1'b1;
                        res.any_change = frame_changed_next;
                    end
                    run_begin_next     = '0;
                    frame_changed_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            row_diff_reg      <= 1'b0;
            run_open_reg      <= 1'b0;
            run_begin_reg     <= '0;
            frame_changed_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= accept;
            end
            if (advance)
            begin
                row_diff_reg      <= row_diff_next;
                run_open_reg      <= run_open_next;
                run_begin_reg     <= run_begin_next;
                frame_changed_reg <= frame_changed_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg   <= pos_in;
            s1_row_reg   <= row_in;
            s1_pixel_reg <= pixel_in;
        end
        if (advance && emit)
        begin
            span_reg <= res;
        end
    end
endmodule

@@ rtl/row_damage_run_tracker_unit.sv @@
// Channel   Dir  Word                                   Handshake
// pixels    in   pixel, start_of_frame                  valid/ready
// spans     out  run_top, run_bottom, rect_valid,       valid/ready
//                whole_frame, frame_end, any_change
// cfg       in   cfg_index, cfg_data                    cfg_we, no back-pressure
//
// Throughput is one pixel per clock unless a stalled result backs up the compare
// stage; the frame store has one read and one write port and each pixel uses both
// once, in the cycle it is accepted. A result word passes the store read and then
// the result register after its pixel is accepted.
// Reset clears control only: the store is not swept and its contents mean nothing
// until a whole frame has passed, which is why that first frame is reported whole.
// A stalled result holds in the output register while one more pixel waits in the
// compare stage; only then does pixels.ready drop.
module row_damage_run_tracker_unit
    import rdrt_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rdrt_pixel_if.sink           pixels,
    rdrt_span_if.source          spans,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               accept;
    logic               take;
    logic [ADDR_W-1:0]  addr;
    logic [ROW_W-1:0]   row;
    pos_t               pos;
    logic [PIXEL_W-1:0] rdata;
    span_t              span;

    // Take a pixel whenever the compare stage is free or about to move on
    assign pixels.ready = take;
    assign accept       = pixels.valid && take;

    // Position counters, size registers and the store address
    rdrt_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .sof       (pixels.start_of_frame),
        .addr      (addr),
        .row       (row),
        .pos       (pos)
    );

    // Previous frame: read the old word and overwrite it in the same cycle
    rdrt_ram #(
        .DATA_W (PIXEL_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (addr),
        .wdata (pixels.pixel),
        .re    (accept),
        .raddr (addr),
        .rdata (rdata)
    );

    // Compare, row classification, run tracking and the result register
    rdrt_run #(
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_run (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pos_in    (pos),
        .row_in    (row),
        .pixel_in  (pixels.pixel),
        .rdata     (rdata),
        .take      (take),
        .out_valid (spans.valid),
        .out_ready (spans.ready),
        .span      (span)
    );

    assign spans.run_top     = span.run_top;
    assign spans.run_bottom  = span.run_bottom;
    assign spans.rect_valid  = span.rect_valid;
    assign spans.whole_frame = span.whole_frame;
    assign spans.frame_end   = span.frame_end;
    assign spans.any_change  = span.any_change;
endmodule

@@ rtl/rdrt_checker.sv @@
module rdrt_checker
    import rdrt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                span_valid,
    input logic                span_ready,
    input logic [TOP_W-1:0]    run_top,
    input logic [BOTTOM_W-1:0] run_bottom,
    input logic                rect_valid,
    input logic                whole_frame,
    input logic                frame_end,
    input logic                any_change
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && !span_ready |=> span_valid && $stable(run_top) && $stable(run_bottom)
            && $stable(rect_valid) && $stable(whole_frame) && $stable(frame_end)
            && $stable(any_change))
        else $error("result word changed while stalled");

    a_whole: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && whole_frame |-> frame_end && rect_valid && any_change && run_top == '0)
        else $error("whole-frame word malformed");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && !rect_valid |-> frame_end && run_top == '0 && run_bottom == '0)
        else $error("word without span malformed");

    a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && !frame_end |-> rect_valid && !any_change && !whole_frame)
        else $error("mid-frame word malformed");

    a_any: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && frame_end && rect_valid |-> any_change)
        else $error("frame end with span lacks any_change");
endmodule

bind row_damage_run_tracker_unit rdrt_checker u_rdrt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .span_valid  (spans.valid),
    .span_ready  (spans.ready),
    .run_top     (spans.run_top),
    .run_bottom  (spans.run_bottom),
    .rect_valid  (spans.rect_valid),
    .whole_frame (spans.whole_frame),
    .frame_end   (spans.frame_end),
    .any_change  (spans.any_change)
);

@@ tb/row_damage_run_tracker_unit_test.sv @@
module row_damage_run_tracker_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdrt_pkg::*;

    localparam int MAX_W         = DEF_MAX_WIDTH;
    localparam int MAX_H         = DEF_MAX_HEIGHT;
    localparam int QUIET_LIMIT   = 4000;   // cycles with no word moving on either channel
    localparam int HOLD_CYCLES   = 80;     // long output hold-off, enough to back up the pipe
    localparam int SETTLE_CYCLES = 6;      // lets pixels that produce no result drain from the pipe

    // Handshake behaviour of the two channels during one stretch of the run
    typedef enum int
    {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } flow_mode_t;

    typedef struct packed
    {
        logic [PIXEL_W-1:0] pixel;
        logic               sof;
    } pixel_word_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rdrt_pixel_if pixel_ch ();
    rdrt_span_if  span_ch ();

    row_damage_run_tracker_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixel_ch),
        .spans     (span_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Words waiting to be offered, and span words the tracker still owes us
    pixel_word_t pending_pixels[$];
    span_t       expected_spans[$];

    flow_mode_t flow_mode = FLOW_FREE;
    int         burst_req = 0;
    int         burst_done;
    int         hold_left;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;

    // Picture the stimulus side believes is on screen, used to repeat or alter rows
    logic [PIXEL_W-1:0] shown_frame [int unsigned];
    bit                 mid_frame = 1'b0;

    // Span tracker state as the predictor sees it
    logic [PIXEL_W-1:0] stored_frame [int unsigned];
    logic [CFG_W-1:0]   width_reg  = RESET_SIZE;
    logic [CFG_W-1:0]   height_reg = RESET_SIZE;
    bit                 prev_valid  = 1'b0;
    int                 col_pos     = 0;
    int                 row_pos     = 0;
    bit                 row_dirty   = 1'b0;
    bit                 run_active  = 1'b0;
    int                 run_start   = 0;
    bit                 frame_dirty = 1'b0;

    function automatic int clamp_size(input logic [CFG_W-1:0] v, input int max_size);
        if (v < 1)
            return 1;
        if (v > max_size)
            return max_size;
        return v;
    endfunction

    function automatic span_t make_span(input int top, input int bottom, input bit rect,
                                        input bit whole, input bit fend, input bit any);
        span_t s;
        s.run_top     = TOP_W'(top);
        s.run_bottom  = BOTTOM_W'(bottom);
        s.rect_valid  = rect;
        s.whole_frame = whole;
        s.frame_end   = fend;
        s.any_change  = any;
        return s;
    endfunction

    // Advance the tracker by one accepted pixel; return 1 when it owes a span word
    function automatic bit predict_span(input logic [PIXEL_W-1:0] px, input logic sof,
                                        output span_t res);
        int          w;
        int          h;
        int unsigned addr;
        bit          differs;
        bit          frame_last;
        bit          changed;
        bit          got;
        res = '0;
        got = 1'b0;
        w = clamp_size(width_reg, MAX_W);
        h = clamp_size(height_reg, MAX_H);
        if (sof)
        begin
            col_pos     = 0;
            row_pos     = 0;
            row_dirty   = 1'b0;
            run_active  = 1'b0;
            run_start   = 0;
            frame_dirty = 1'b0;
        end
        addr = (row_pos * MAX_W + col_pos) % (MAX_W * MAX_H);
        differs = stored_frame.exists(addr) ? (stored_frame[addr] != px) : (px != '0);
        stored_frame[addr] = px;

        if (col_pos + 1 < w)
        begin
            row_dirty = row_dirty || differs;
            col_pos++;
            return 1'b0;
        end

        frame_last = (row_pos + 1) >= h;
        changed    = row_dirty || differs;
        row_dirty  = 1'b0;
        col_pos    = 0;

        // No trustworthy previous picture: the whole screen goes out at the last pixel
        if (!prev_valid)
        begin
            run_active = 1'b0;
            if (frame_last)
            begin
                res         = make_span(0, row_pos + 1, 1'b1, 1'b1, 1'b1, 1'b1);
                prev_valid  = 1'b1;
                row_pos     = 0;
                frame_dirty = 1'b0;
                return 1'b1;
            end
            row_pos++;
            return 1'b0;
        end

        if (changed && !run_active)
        begin
            run_active = 1'b1;
            run_start  = row_pos;
        end
        else if (!changed && run_active)
        begin
            // A clean row closes the run; on the last row it shares the frame-end word
            run_active  = 1'b0;
            frame_dirty = 1'b1;
            res = make_span(run_start, row_pos, 1'b1, 1'b0, frame_last,
                            frame_last ? frame_dirty : 1'b0);
            got = 1'b1;
        end

        if (frame_last)
        begin
            if (run_active)
            begin
                run_active  = 1'b0;
                frame_dirty = 1'b1;
                res = make_span(run_start, row_pos + 1, 1'b1, 1'b0, 1'b1, 1'b1);
            end
            else if (!got)
                res = make_span(0, 0, 1'b0, 1'b0, 1'b1, frame_dirty);
            got         = 1'b1;
            row_pos     = 0;
            run_start   = 0;
            frame_dirty = 1'b0;
        end
        else
            row_pos++;
        return got;
    endfunction

    function automatic bit sender_rests();
        case (flow_mode)
            FLOW_SENDER_IDLE: return $urandom_range(99) < 77;
            FLOW_BOTH:        return $urandom_range(99) < 30;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic bit sink_holds();
        case (flow_mode)
            FLOW_SINK_STALL: return $urandom_range(99) < 77;
            FLOW_BOTH:       return $urandom_range(99) < 30;
            default:         return 1'b0;
        endcase
    endfunction

    // Pixel driver: predict on every accepted word, then offer the next one or idle.
    // A word on offer is held until taken.
    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        pixel_word_t head_word;
        span_t       span_word;
        if (!rst_n)
        begin
            pixel_ch.valid          <= 1'b0;
            pixel_ch.pixel          <= '0;
            pixel_ch.start_of_frame <= 1'b0;
        end
        else
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                if (predict_span(pixel_ch.pixel, pixel_ch.start_of_frame, span_word))
                    expected_spans.push_back(span_word);
            end
            if (!pixel_ch.valid || pixel_ch.ready)
            begin
                if (pending_pixels.size() != 0 && !sender_rests())
                begin
                    head_word = pending_pixels.pop_front();
                    pixel_ch.valid          <= 1'b1;
                    pixel_ch.pixel          <= head_word.pixel;
                    pixel_ch.start_of_frame <= head_word.sof;
                end
                else
                    pixel_ch.valid <= 1'b0;
            end
        end
    end

    // Span monitor: check each accepted word against the oldest expectation, then
    // choose ready for the next cycle. A burst request holds ready low for a long
    // stretch so the tracker backs up and drops pixels.ready.
    always @(posedge clk or negedge rst_n)
    begin : check_spans
        span_t seen;
        span_t want;
        if (!rst_n)
        begin
            span_ch.ready <= 1'b0;
            hold_left     <= 0;
            burst_done    <= 0;
        end
        else
        begin
            if (span_ch.valid && span_ch.ready)
            begin
                seen = {span_ch.run_top, span_ch.run_bottom, span_ch.rect_valid,
                        span_ch.whole_frame, span_ch.frame_end, span_ch.any_change};
                if (expected_spans.size() == 0)
                begin
                    $display("%0t: unexpected span word expected none, actual top=%0d",
                             $time, seen.run_top,
                             " bottom=%0d rect=%0b whole=%0b end=%0b any=%0b",
                             seen.run_bottom, seen.rect_valid, seen.whole_frame,
                             seen.frame_end, seen.any_change);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_spans.pop_front();
                    if (seen !== want)
                    begin
                        $display("%0t: span mismatch expected top=%0d", $time,
                                 want.run_top,
                                 " bottom=%0d rect=%0b whole=%0b end=%0b any=%0b",
                                 want.run_bottom, want.rect_valid, want.whole_frame,
                                 want.frame_end, want.any_change);
                        $display("%0t:               actual top=%0d", $time,
                                 seen.run_top,
                                 " bottom=%0d rect=%0b whole=%0b end=%0b any=%0b",
                                 seen.run_bottom, seen.rect_valid, seen.whole_frame,
                                 seen.frame_end, seen.any_change);
                        mismatch_count++;
                    end
                end
            end
            if (burst_req != burst_done)
            begin
                hold_left     <= HOLD_CYCLES;
                burst_done    <= burst_req;
                span_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                span_ch.ready <= 1'b0;
            end
            else
                span_ch.ready <= !sink_holds();
        end
    end

    // Watchdog: give up once neither channel has moved a word for too long
    always @(posedge clk)
    begin
        if ((pixel_ch.valid && pixel_ch.ready) || (span_ch.valid && span_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_pixel(input int unsigned addr, input logic [PIXEL_W-1:0] value,
                               input logic sof);
        shown_frame[addr] = value;
        pending_pixels.push_back('{pixel: value, sof: sof});
    endtask

    // Queue one frame in raster order. Rows flagged dirty differ in at least one
    // pixel; the rest repeat what is on screen. A cut stops the frame early.
    task automatic queue_frame(input int w, input int h, input bit [MAX_H-1:0] dirty,
                               input bit lead_sof, input int cut);
        int                 sent;
        int                 hot_col;
        int unsigned        addr;
        logic [PIXEL_W-1:0] value;
        logic [PIXEL_W-1:0] flip;
        sent = 0;
        for (int r = 0; r < h; r++)
        begin
            hot_col = $urandom_range(w - 1);
            for (int c = 0; c < w; c++)
            begin
                if (sent == cut)
                begin
                    mid_frame = 1'b1;
                    return;
                end
                addr  = r * MAX_W + c;
                value = shown_frame.exists(addr) ? shown_frame[addr] : $urandom;
                if (dirty[r] && (c == hot_col || $urandom_range(3) == 0))
                begin
                    // mix single-bit flips with wholesale changes
                    flip = $urandom_range(1) ? (32'd1 << $urandom_range(31)) : $urandom;
                    if (flip == '0)
                        flip = 32'd1;
                    value = value ^ flip;
                end
                queue_pixel(addr, value, lead_sof && sent == 0);
                sent++;
            end
        end
        mid_frame = 1'b0;
    endtask

    function automatic bit [MAX_H-1:0] random_rows(input int h);
        bit [MAX_H-1:0] rows;
        int             pct;
        rows = '0;
        case ($urandom_range(3))
            0:       pct = 0;
            1:       pct = 25;
            2:       pct = 50;
            default: pct = 100;
        endcase
        for (int r = 0; r < h; r++)
            rows[r] = $urandom_range(99) < pct;
        return rows;
    endfunction

    // Random frames; after an abandoned frame the next one must restart with sof,
    // otherwise sof is sometimes left out and the counters wrap on their own
    task automatic queue_frames(input int w, input int h, input int frames,
                                input bit allow_cut);
        int cut;
        bit lead_sof;
        for (int f = 0; f < frames; f++)
        begin
            lead_sof = mid_frame || ($urandom_range(3) != 0);
            cut = -1;
            if (allow_cut && w * h > 1 && $urandom_range(9) == 0)
                cut = $urandom_range(w * h - 1, 1);
            queue_frame(w, h, random_rows(h), lead_sof, cut);
        end
    endtask

    // Hold off until every queued pixel is taken and every span word has arrived,
    // then give the pipe time to empty of pixels that produce nothing. Sample
    // between edges so the driver's and monitor's updates have landed.
    task automatic settle();
        @(negedge clk);
        while (pending_pixels.size() != 0 || pixel_ch.valid || expected_spans.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input cfg_reg_t which, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (which == CFG_FRAME_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        prev_valid = 1'b0;
    endtask

    task automatic set_sizes(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                             input flow_mode_t mode);
        settle();
        flow_mode <= mode;
        write_size(CFG_FRAME_WIDTH, wv);
        write_size(CFG_FRAME_HEIGHT, hv);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                             input flow_mode_t mode, input int frames, input bit allow_cut);
        set_sizes(wv, hv, mode);
        queue_frames(clamp_size(wv, MAX_W), clamp_size(hv, MAX_H), frames, allow_cut);
    endtask

    initial
    begin
        cfg_we                  = 1'b0;
        cfg_index               = CFG_FRAME_WIDTH;
        cfg_data                = '0;
        rst_n                   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sizes of zero clamp to a single pixel, so every word is a whole frame:
        // first the whole-screen report, then unchanged and changed single-row frames
        set_sizes(10'd0, 10'd0, FLOW_FREE);
        queue_pixel(0, 32'hFFFF_FFFF, 1'b1);
        queue_pixel(0, 32'hFFFF_FFFF, 1'b0);
        queue_pixel(0, 32'h0000_0000, 1'b1);
        queue_pixel(0, 32'h0000_0000, 1'b0);
        queue_pixel(0, 32'h8000_0000, 1'b0);
        queue_pixel(0, 32'h0000_0001, 1'b1);

        // Two by three: whole frame; changed-clean-changed gives a closed run and one
        // ending on the last row; clean-changed-clean closes a run together with the
        // frame end; an untouched frame reports frame end alone
        set_sizes(10'd2, 10'd3, FLOW_FREE);
        queue_frame(2, 3, '1, 1'b1, -1);
        queue_frame(2, 3, 3'b101, 1'b1, -1);
        queue_frame(2, 3, 3'b010, 1'b0, -1);
        queue_frame(2, 3, '0, 1'b1, -1);

        // Single-pixel frames at full rate, then hold the output long enough to
        // back the tracker up while pixels keep coming
        run_phase(10'd1, 10'd1, FLOW_FREE, 30, 1'b1);
        repeat (10) @(posedge clk);
        burst_req <= burst_req + 1;

        run_phase(10'd5, 10'd4, FLOW_SENDER_IDLE, 4, 1'b1);

        // Narrow the rows in the middle of a frame: the counters carry on under the
        // new width and the rest of that frame comes out whole
        run_phase(10'd8, 10'd6, FLOW_SINK_STALL, 1, 1'b0);
        queue_frame(8, 6, random_rows(6), 1'b1, 19);
        settle();
        write_size(CFG_FRAME_WIDTH, 10'd4);
        queue_pixel(2 * MAX_W + 3, $urandom, 1'b0);
        for (int r = 3; r < 6; r++)
            for (int c = 0; c < 4; c++)
                queue_pixel(r * MAX_W + c, $urandom, 1'b0);
        mid_frame = 1'b0;
        queue_frames(4, 6, 2, 1'b1);

        run_phase(10'd7, 10'd3, FLOW_BOTH, 4, 1'b1);
        run_phase(10'd3, 10'd9, FLOW_SINK_STALL, 3, 1'b1);
        run_phase(10'd6, 10'd2, FLOW_BOTH, 5, 1'b1);

        settle();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
